// ===== design/uap_pkg.sv =====
// shared types and codes for the utilization admission table
package uap_pkg;

  localparam int unsigned UtilW  = 17;
  localparam int unsigned TotalW = 21;

  localparam logic [1:0] OpAdd     = 2'd0;
  localparam logic [1:0] OpRemove  = 2'd1;
  localparam logic [1:0] OpRefresh = 2'd2;
  localparam logic [1:0] OpNone    = 2'd3;

  localparam logic [2:0] StEntry    = 3'd0;
  localparam logic [2:0] StOverLim  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StRemoved  = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StEmpty    = 3'd5;

  localparam logic [UtilW-1:0] UtilMax      = 17'h1FFFF;
  localparam logic [UtilW-1:0] UtilLimitRst = 17'd45875;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  task_id;
    logic [7:0]  compute_time;
    logic [15:0] period;
  } req_t;

endpackage

// ===== design/uap_front.sv =====
// request intake: drops no-op requests and queues the rest for the back end
module uap_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  uap_pkg::req_t in_req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output uap_pkg::req_t q_req_o
);
  import uap_pkg::*;

  req_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && (in_req_i.operation != OpNone);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_req_i;
    end
  end

endmodule

// ===== design/uap_back.sv =====
// request execution: utilization divide, admission, removal and period ranking
module uap_back #(
  parameter int unsigned MaxTasks = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_data_i,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  uap_pkg::req_t q_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    status_o,
  output logic [7:0]    task_id_res_o,
  output logic [4:0]    priority_res_o,
  output logic          last_o
);
  import uap_pkg::*;

  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxTasks - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ADMIT, S_REMOVE, S_RANK_I, S_RANK_J, S_RANK_OUT, S_SINGLE
  } state_e;

  state_e              state_q;
  req_t                req_q;
  logic [UtilW-1:0]    limit_q;
  logic [TotalW-1:0]   total_q;
  logic [MaxTasks-1:0] valid_q;
  logic [7:0]          id_mem_q   [MaxTasks];
  logic [15:0]         per_mem_q  [MaxTasks];
  logic [UtilW-1:0]    util_mem_q [MaxTasks];
  logic [23:0]         nq_q;
  logic [16:0]         rem_q;
  logic [4:0]          div_cnt_q;
  logic [IdxW-1:0]     i_q, j_q;
  logic [CntW-1:0]     rank_q;
  logic [15:0]         cur_per_q;
  logic [2:0]          sgl_st_q;
  logic [7:0]          sgl_id_q;
  logic                out_valid_q;
  logic [2:0]          status_q;
  logic [7:0]          id_res_q;
  logic [4:0]          pr_res_q;
  logic                last_q;

  logic                out_free;
  logic [16:0]         rem_sh;
  logic                div_ge;
  logic [UtilW-1:0]    util;
  logic [TotalW:0]     sum;
  logic                any_free;
  logic [IdxW-1:0]     free_idx;
  logic [IdxW-1:0]     rd_idx;
  logic                rd_valid;
  logic [7:0]          rd_id;
  logic [15:0]         rd_per;
  logic [UtilW-1:0]    rd_util;
  logic                higher;
  logic                wr_en;
  logic                clr_en;

  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign task_id_res_o  = id_res_q;
  assign priority_res_o = pr_res_q;
  assign last_o         = last_q;
  assign q_pop_o        = (state_q == S_IDLE) && q_valid_i;

  assign rem_sh = {rem_q[15:0], nq_q[23]};
  assign div_ge = (rem_sh >= {1'b0, req_q.period});

  always_comb begin
    if (req_q.period == 16'd0 || nq_q[23:17] != 7'd0) begin
      util = UtilMax;
    end else begin
      util = nq_q[16:0];
    end
    sum = {1'b0, total_q} + (TotalW+1)'(util);
  end

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int k = MaxTasks - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        any_free = 1'b1;
        free_idx = IdxW'(k);
      end
    end
  end

  assign rd_idx   = (state_q == S_RANK_J || state_q == S_REMOVE) ? j_q : i_q;
  assign rd_valid = valid_q[rd_idx];
  assign rd_id    = id_mem_q[rd_idx];
  assign rd_per   = per_mem_q[rd_idx];
  assign rd_util  = util_mem_q[rd_idx];

  always_comb begin
    higher = 1'b0;
    for (int k = 0; k < MaxTasks; k++) begin
      if (valid_q[k] && IdxW'(k) > i_q) begin
        higher = 1'b1;
      end
    end
  end

  assign wr_en  = (state_q == S_ADMIT) && (sum < {5'd0, limit_q}) && any_free;
  assign clr_en = (state_q == S_REMOVE) && rd_valid && (rd_id == req_q.task_id);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem_q[free_idx]   <= req_q.task_id;
      per_mem_q[free_idx]  <= req_q.period;
      util_mem_q[free_idx] <= util;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= UtilLimitRst;
      total_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      req_q       <= '0;
      nq_q        <= '0;
      rem_q       <= '0;
      cur_per_q   <= '0;
      sgl_st_q    <= '0;
      sgl_id_q    <= '0;
      status_q    <= '0;
      id_res_q    <= '0;
      pr_res_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_RANK_OUT && state_q != S_SINGLE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q <= q_req_i;
            i_q   <= '0;
            j_q   <= '0;
            unique case (q_req_i.operation)
              OpAdd: begin
                nq_q      <= {q_req_i.compute_time, 16'd0};
                rem_q     <= '0;
                div_cnt_q <= '0;
                state_q   <= S_DIV;
              end
              OpRemove: begin
                state_q <= S_REMOVE;
              end
              default: begin
                if (valid_q == '0) begin
                  sgl_st_q <= StEmpty;
                  sgl_id_q <= '0;
                  state_q  <= S_SINGLE;
                end else if (!(total_q < {4'd0, limit_q})) begin
                  sgl_st_q <= StOverLim;
                  sgl_id_q <= '0;
                  state_q  <= S_SINGLE;
                end else begin
                  state_q <= S_RANK_I;
                end
              end
            endcase
          end
        end
        S_DIV: begin
          rem_q     <= div_ge ? (rem_sh - {1'b0, req_q.period}) : rem_sh;
          nq_q      <= {nq_q[22:0], div_ge};
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'd23) begin
            state_q <= S_ADMIT;
          end
        end
        S_ADMIT: begin
          sgl_id_q <= req_q.task_id;
          if (!(sum < {5'd0, limit_q})) begin
            sgl_st_q <= StOverLim;
            state_q  <= S_SINGLE;
          end else if (!any_free) begin
            sgl_st_q <= StFull;
            state_q  <= S_SINGLE;
          end else begin
            valid_q[free_idx] <= 1'b1;
            total_q           <= sum[TotalW-1:0];
            state_q           <= S_RANK_I;
          end
        end
        S_REMOVE: begin
          sgl_id_q <= req_q.task_id;
          if (clr_en) begin
            valid_q[j_q] <= 1'b0;
            total_q      <= total_q - TotalW'(rd_util);
            sgl_st_q     <= StRemoved;
            state_q      <= S_SINGLE;
          end else if (j_q == LastIdx) begin
            sgl_st_q <= StNotFound;
            state_q  <= S_SINGLE;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_RANK_I: begin
          if (rd_valid) begin
            cur_per_q <= rd_per;
            rank_q    <= '0;
            j_q       <= '0;
            state_q   <= S_RANK_J;
          end else if (i_q == LastIdx) begin
            state_q <= S_IDLE;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_RANK_J: begin
          if (rd_valid && rd_per >= cur_per_q) begin
            rank_q <= rank_q + 1'b1;
          end
          if (j_q == LastIdx) begin
            state_q <= S_RANK_OUT;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_RANK_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= StEntry;
            id_res_q    <= rd_id;
            pr_res_q    <= 5'(rank_q);
            last_q      <= !higher;
            if (!higher) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RANK_I;
            end
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= sgl_st_q;
            id_res_q    <= sgl_id_q;
            pr_res_q    <= '0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/utilization_admission_priority_table.sv =====
// top level of the utilization admission and priority table
// add: a bit-serial divide and the admission check, then, if admitted, for each stored task
// a scan of every slot; remove: a scan of the slots for the id; refresh: ranking only; the
// divide loop and the one-compare-per-cycle ranking scan handle one request at a time
// a two-entry request queue lets up to two requests wait while one executes
// reset empties the table, clears the total and loads the limit with 0.7
module utilization_admission_priority_table #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  compute_time_i,
  input  logic [15:0] period_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  task_id_res_o,
  output logic [4:0]  priority_res_o,
  output logic        last_o
);
  import uap_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_req.operation    = operation_i;
    in_req.task_id      = task_id_i;
    in_req.compute_time = compute_time_i;
    in_req.period       = period_i;
  end

  uap_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  uap_back #(
    .MaxTasks (MAX_TASKS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_req_i        (q_req),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .task_id_res_o  (task_id_res_o),
    .priority_res_o (priority_res_o),
    .last_o         (last_o)
  );

endmodule

// ===== bench/utilization_admission_priority_table_test.sv =====
// testbench for the utilization admission table: predicts every result and checks each transfer
`timescale 1ns / 100ps
module utilization_admission_priority_table_test;
  import uap_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] task_id;
    logic [4:0] prio;
    logic       last;
  } rank_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [7:0]  task_id;
  logic [7:0]  compute_time;
  logic [15:0] period;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [7:0]  task_id_res;
  logic [4:0]  priority_res;
  logic        last;

  // predictor state
  bit                slot_used [NumSlots];
  logic [7:0]        slot_id   [NumSlots];
  logic [15:0]       slot_per  [NumSlots];
  logic [UtilW-1:0]  slot_util [NumSlots];
  logic [TotalW-1:0] util_sum;
  logic [UtilW-1:0]  limit_q16;

  rank_res_t expected_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  int unsigned error_count;

  utilization_admission_priority_table #(.MAX_TASKS(NumSlots)) DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .task_id_i(task_id),
    .compute_time_i(compute_time), .period_i(period),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .task_id_res_o(task_id_res),
    .priority_res_o(priority_res), .last_o(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_single(logic [2:0] st, logic [7:0] id);
    expected_q.push_back('{status: st, task_id: id, prio: 5'd0, last: 1'b1});
  endfunction

  function automatic void push_ranking();
    int n;
    int unsigned pr;
    n = 0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_used[i]) begin
        pr = 0;
        for (int j = 0; j < NumSlots; j++)
          if (slot_used[j] && slot_per[j] >= slot_per[i]) pr++;
        expected_q.push_back('{status: StEntry, task_id: slot_id[i], prio: pr[4:0],
                               last: 1'b0});
        n++;
      end
    end
    if (n > 0) expected_q[$].last = 1'b1;
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [7:0] id, logic [7:0] ct,
                                          logic [15:0] per);
    logic [31:0] quot;
    logic [UtilW-1:0] util;
    logic [TotalW:0] sum;
    int free_slot;
    bit any;
    bit found;
    free_slot = -1;
    any = 0;
    found = 0;
    case (op)
      OpAdd: begin
        if (per == 0) util = UtilMax;
        else begin
          quot = ({24'd0, ct} << 16) / per;
          util = (quot > UtilMax) ? UtilMax : quot[UtilW-1:0];
        end
        sum = util_sum + util;
        if (!(sum < limit_q16)) push_single(StOverLim, id);
        else begin
          for (int i = NumSlots - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
          if (free_slot < 0) push_single(StFull, id);
          else begin
            slot_used[free_slot] = 1;
            slot_id[free_slot] = id;
            slot_per[free_slot] = per;
            slot_util[free_slot] = util;
            util_sum = sum[TotalW-1:0];
            push_ranking();
          end
        end
      end
      OpRemove: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (!found && slot_used[i] && slot_id[i] == id) begin
            found = 1;
            slot_used[i] = 0;
            util_sum = util_sum - slot_util[i];
          end
        end
        push_single(found ? StRemoved : StNotFound, id);
      end
      OpRefresh: begin
        for (int i = 0; i < NumSlots; i++) if (slot_used[i]) any = 1;
        if (!any) push_single(StEmpty, 8'd0);
        else if (!(util_sum < limit_q16)) push_single(StOverLim, 8'd0);
        else push_ranking();
      end
      default: ;
    endcase
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    rank_res_t exp_res;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transfer: status %0d task_id %0d", status, task_id_res);
          error_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            error_count++;
          end
          if (task_id_res !== exp_res.task_id) begin
            $error("task_id_res: expected %0d, got %0d", exp_res.task_id, task_id_res);
            error_count++;
          end
          if (priority_res !== exp_res.prio) begin
            $error("priority_res: expected %0d, got %0d", exp_res.prio, priority_res);
            error_count++;
          end
          if (last !== exp_res.last) begin
            $error("last: expected %0d, got %0d", exp_res.last, last);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] op, logic [7:0] id, logic [7:0] ct,
                              logic [15:0] per);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    task_id <= id;
    compute_time <= ct;
    period <= per;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, id, ct, per);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_limit(logic [16:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_q16 = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request(int unsigned id_span);
    logic [7:0] ct;
    logic [15:0] per;
    int unsigned pick;
    pick = $urandom_range(99);
    ct = 8'($urandom_range(255, 1));
    case ($urandom_range(3))
      0: per = 16'($urandom_range(65535, ct));
      1: per = 16'($urandom_range(2000, ct));
      2: per = 16'($urandom_range(65535, 0));
      default: per = 16'(ct * $urandom_range(60, 4));
    endcase
    if (pick < 50) send_request(OpAdd, 8'($urandom_range(id_span)), ct, per);
    else if (pick < 80) send_request(OpRemove, 8'($urandom_range(id_span)), ct, per);
    else if (pick < 95) send_request(OpRefresh, 8'($urandom_range(255)), ct, per);
    else send_request(OpNone, 8'($urandom_range(255)), ct, per);
  endtask

  task automatic test_directed();
    send_request(OpRefresh, 8'd0, 8'd1, 16'd1);
    send_request(OpRemove, 8'd9, 8'd1, 16'd1);
    send_request(OpAdd, 8'd255, 8'd255, 16'd0);
    send_request(OpAdd, 8'd1, 8'd255, 16'd100);
    send_request(OpAdd, 8'd0, 8'd1, 16'd65535);
    send_request(OpAdd, 8'd7, 8'd1, 16'd40);
    send_request(OpAdd, 8'd7, 8'd2, 16'd40);
    send_request(OpAdd, 8'd255, 8'd1, 16'd1000);
    send_request(OpNone, 8'd255, 8'd255, 16'hFFFF);
    send_request(OpRefresh, 8'd0, 8'd1, 16'd1);
    send_request(OpRemove, 8'd7, 8'd1, 16'd1);
    send_request(OpRemove, 8'd99, 8'd1, 16'd1);
    send_request(OpRefresh, 8'hAA, 8'd1, 16'd1);
  endtask

  task automatic test_full_table();
    write_limit(17'h1FFFF);
    for (int i = 0; i < 17; i++) send_request(OpAdd, 8'(i + 32), 8'd1, 16'(1000 + 7 * i));
    send_request(OpRefresh, 8'd0, 8'd1, 16'd1);
    // lowered limit makes refresh answer over limit
    write_limit(17'd0);
    send_request(OpRefresh, 8'd0, 8'd1, 16'd1);
    send_request(OpAdd, 8'd5, 8'd1, 16'd65535);
    write_limit(17'h10000);
    for (int i = 0; i < 18; i++) send_request(OpRemove, 8'(i + 32), 8'd1, 16'd1);
  endtask

  task automatic test_random(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_random_request(($urandom_range(3) == 0) ? 255 : 15);
  endtask

  task automatic test_pause_until_drained();
    send_request(OpAdd, 8'd3, 8'd2, 16'd50);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    send_request(OpRefresh, 8'd0, 8'd1, 16'd1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OpNone;
    task_id = '0;
    compute_time = '0;
    period = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_count = 0;
    error_count = 0;
    util_sum = '0;
    limit_q16 = UtilLimitRst;
    for (int i = 0; i < NumSlots; i++) begin
      slot_used[i] = 0;
      slot_id[i] = '0;
      slot_per[i] = '0;
      slot_util[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(100, 0, 0);
    write_limit(UtilLimitRst);
    test_random(100, 66, 0);
    test_pause_until_drained();
    write_limit(17'd30000);
    test_random(100, 0, 66);
    write_limit(17'h1FFFF);
    test_random(100, 10, 10);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/uap_pkg.sv
design/uap_front.sv
design/uap_back.sv
design/utilization_admission_priority_table.sv
bench/utilization_admission_priority_table_test.sv
